[src/asr_pkg.sv]
// Shared types and constants for the argsort rank engine.
// The controller, datapath and top level import this package; it depends on nothing else.
package asr_pkg;

   // Capacity of one set and width of one stored value.
   localparam int MAX_ITEMS   = 64;
   localparam int VALUE_WIDTH = 32;

   // Width of an arrival index or a sorted rank, and of a count that can reach MAX_ITEMS.
   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   // Flipping the sign bit makes unsigned key order equal signed value order.
   localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

   // Controller states.
   typedef enum logic [2:0] {
      S_LOAD,
      S_FETCH_I,
      S_LATCH_I,
      S_SCAN,
      S_OUT_ADDR,
      S_OUT_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // input channel is open
      logic rd_i;        // key memory reads the element being ranked
      logic start_scan;  // latch that element's key and clear the rank count
      logic scan;        // step the comparison sweep
      logic commit;      // write rank and sorted index of the element
      logic out_load;    // move one result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic close;       // the transaction taken now closes the set
      logic scan_done;   // every comparison for the current element is counted
      logic pos_last;    // position counter is at the last stored element
      logic out_free;    // output register can take a new result
   } status_type;

endpackage

[src/asr_ram.sv]
// Generic single-port-write, single-port-read memory with registered read data.
// No dependencies.
module asr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/asr_ctrl.sv]
// Sequencer of the argsort rank engine: loading, ranking sweep and result output.
// Depends on asr_pkg for the state, command and status types.
module asr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  asr_pkg::status_type status,
   output asr_pkg::cmd_type    cmd
);
   import asr_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_LOAD: begin
            cmd.load = 1'b1;
            if (status.close) begin
               state_in = S_FETCH_I;
            end
         end
         S_FETCH_I: begin
            cmd.rd_i = 1'b1;
            state_in = S_LATCH_I;
         end
         S_LATCH_I: begin
            cmd.start_scan = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               cmd.commit = 1'b1;
               state_in   = status.pos_last ? S_OUT_ADDR : S_FETCH_I;
            end
         end
         S_OUT_ADDR: begin
            state_in = S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.pos_last ? S_LOAD : S_OUT_ADDR;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

[src/asr_datapath.sv]
// Datapath of the argsort rank engine: key memory, comparison sweep, rank and
// index memories, configuration register and output register.
// Depends on asr_pkg and asr_ram.
module asr_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  asr_pkg::cmd_type                      cmd,
   output asr_pkg::status_type                   status,
   input  logic                                  req_valid,
   input  logic signed [asr_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                  req_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [asr_pkg::IDX_W-1:0]             rsp_order_to_index,
   output logic [asr_pkg::IDX_W-1:0]             rsp_index_to_order,
   output logic                                  rsp_overflow,
   output logic                                  rsp_last_result
);
   import asr_pkg::*;

   // Control registers.
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic             cmp_en_ff, cmp_en_in;
   logic             descending_ff, descending_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [VALUE_WIDTH-1:0] key_i_ff, key_i_in;
   logic [IDX_W-1:0]       jd_ff, jd_in;
   logic [IDX_W-1:0]       rank_ff, rank_in;
   logic [IDX_W-1:0]       rsp_oti_ff, rsp_oti_in;
   logic [IDX_W-1:0]       rsp_ito_ff, rsp_ito_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                   key_wr_en;
   logic [VALUE_WIDTH-1:0] key_wr_data;
   logic [IDX_W-1:0]       key_rd_addr;
   logic [VALUE_WIDTH-1:0] key_rd_data;
   logic [IDX_W-1:0]       rank_rd_data;
   logic [IDX_W-1:0]       index_rd_data;

   logic accept;
   logic full;
   logic j_ahead;
   logic pos_last;

   asr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (key_wr_data),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   // Arrival index to sorted rank.
   asr_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_rank_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (pos_ff),
      .wr_data (rank_ff),
      .rd_addr (pos_ff),
      .rd_data (rank_rd_data)
   );

   // Sorted position to arrival index.
   asr_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_index_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (rank_ff),
      .wr_data (pos_ff),
      .rd_addr (pos_ff),
      .rd_data (index_rd_data)
   );

   assign accept      = cmd.load & req_valid;
   assign full        = (count_ff == CNT_W'(MAX_ITEMS));
   assign key_wr_en   = accept & ~full;
   assign key_wr_data = req_value ^ SIGN_FLIP;
   assign key_rd_addr = cmd.rd_i ? pos_ff : j_ff[IDX_W-1:0];
   assign pos_last    = ({1'b0, pos_ff} + CNT_W'(1)) == count_ff;

   // Element j goes before element i: strict key order, ties by arrival.
   always_comb begin
      if (key_rd_data != key_i_ff) begin
         j_ahead = descending_ff ? (key_rd_data > key_i_ff) : (key_rd_data < key_i_ff);
      end else begin
         j_ahead = (jd_ff < pos_ff);
      end
   end

   // Next values of all registers.
   always_comb begin
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      pos_in        = pos_ff;
      j_in          = j_ff;
      cmp_en_in     = cmp_en_ff;
      descending_in = descending_ff;
      rsp_valid_in  = rsp_valid_ff;
      key_i_in      = key_i_ff;
      jd_in         = jd_ff;
      rank_in       = rank_ff;
      rsp_oti_in    = rsp_oti_ff;
      rsp_ito_in    = rsp_ito_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;

      // Configuration write.
      if (csr_valid) begin
         descending_in = csr_data;
      end

      // Store an arriving element, or flag it as dropped when the set is full.
      if (accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         if (req_last) begin
            pos_in = '0;
         end
      end

      // Begin the comparison sweep for the element at pos.
      if (cmd.start_scan) begin
         key_i_in  = key_rd_data;
         rank_in   = '0;
         j_in      = '0;
         cmp_en_in = 1'b0;
      end

      // Issue one read per cycle and count the elements that go before.
      if (cmd.scan) begin
         if (j_ff != count_ff) begin
            j_in      = j_ff + CNT_W'(1);
            jd_in     = j_ff[IDX_W-1:0];
            cmp_en_in = 1'b1;
         end else begin
            cmp_en_in = 1'b0;
         end
         if (cmp_en_ff && j_ahead) begin
            rank_in = rank_ff + IDX_W'(1);
         end
      end

      // Rank is written; move to the next element or to the output sweep.
      if (cmd.commit) begin
         pos_in = pos_last ? '0 : pos_ff + IDX_W'(1);
      end

      // Output register: a taken transaction frees it, a new result fills it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_oti_in   = index_rd_data;
         rsp_ito_in   = rank_rd_data;
         rsp_ovf_in   = dropped_ff;
         rsp_last_in  = pos_last;
         if (pos_last) begin
            pos_in     = '0;
            count_in   = '0;
            dropped_in = 1'b0;
         end else begin
            pos_in = pos_ff + IDX_W'(1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         pos_ff        <= '0;
         j_ff          <= '0;
         cmp_en_ff     <= 1'b0;
         descending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         pos_ff        <= pos_in;
         j_ff          <= j_in;
         cmp_en_ff     <= cmp_en_in;
         descending_ff <= descending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_i_ff    <= key_i_in;
      jd_ff       <= jd_in;
      rank_ff     <= rank_in;
      rsp_oti_ff  <= rsp_oti_in;
      rsp_ito_ff  <= rsp_ito_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Status to the controller.
   always_comb begin
      status.close     = accept & req_last;
      status.scan_done = (j_ff == count_ff) & ~cmp_en_ff;
      status.pos_last  = pos_last;
      status.out_free  = ~rsp_valid_ff | rsp_ready;
   end

   // The register takes writes whenever the block is out of reset.
   assign csr_ready          = ~reset;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_order_to_index = rsp_oti_ff;
   assign rsp_index_to_order = rsp_ito_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_last_result    = rsp_last_ff;

endmodule

[src/argsort_rank_engine.sv]
// Stable argsort with inverse permutation; top level of the block.
// Depends on asr_pkg, asr_ctrl and asr_datapath.
//
// Signed values are loaded one per cycle and numbered by arrival; the transaction
// marked last closes the set, and values beyond MAX_ITEMS are dropped and flagged
// in the overflow field. After closing, the block ranks each of the n stored values
// by sweeping the key memory through its single read port, then emits n results:
// result k gives the arrival index of the element at sorted position k and the
// sorted rank of the element that arrived k-th. Equal values keep arrival order. The
// descending bit selects the order and may be written at any time outside a ranking
// run. A new set can start loading while the last result of the previous one waits
// to be taken.
module argsort_rank_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [asr_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                   req_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic                                   csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [asr_pkg::IDX_W-1:0]              rsp_order_to_index,
   output logic [asr_pkg::IDX_W-1:0]              rsp_index_to_order,
   output logic                                   rsp_overflow,
   output logic                                   rsp_last_result
);
   import asr_pkg::*;

   cmd_type    cmd;
   status_type status;

   asr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   asr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_valid          (req_valid),
      .req_value          (req_value),
      .req_last           (req_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_order_to_index (rsp_order_to_index),
      .rsp_index_to_order (rsp_index_to_order),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result)
   );

   // Input transactions are taken only while the set is loading and out of reset.
   assign req_ready = cmd.load & ~reset;

endmodule

[tb/tb_argsort_rank_engine.sv]
// Self-checking testbench for argsort_rank_engine: random and directed value sets,
// checked against a stable-argsort predictor. Depends on asr_pkg and the block's RTL.
module tb_argsort_rank_engine;
   import asr_pkg::*;

   // Generous upper bound on the run, far above the slowest correct run.
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_LEN = 600;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last;
   } value_item_type;

   typedef struct packed {
      logic [IDX_W-1:0] order_to_index;
      logic [IDX_W-1:0] index_to_order;
      logic             overflow;
      logic             last_result;
   } rank_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          req_last = 1'b0;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic                          csr_data = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [IDX_W-1:0]              rsp_order_to_index;
   logic [IDX_W-1:0]              rsp_index_to_order;
   logic                          rsp_overflow;
   logic                          rsp_last_result;

   // Stimulus and scoreboard storage.
   value_item_type  pending_items[$];
   rank_result_type expected_ranks[$];
   value_item_type  next_item;
   bit              req_took = 1'b0;
   int              errors = 0;
   int              cycle_count = 0;
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   bit              hold_request = 1'b0;
   int              hold_cycles = 0;

   // Predictor state: keys of the set being loaded and the configured order.
   logic [VALUE_WIDTH-1:0] set_keys[MAX_ITEMS];
   logic [IDX_W-1:0]       set_rank[MAX_ITEMS];
   logic [IDX_W-1:0]       set_order[MAX_ITEMS];
   int                     set_count = 0;
   bit                     set_dropped = 1'b0;
   bit                     cfg_descending = 1'b0;

   argsort_rank_engine DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value          (req_value),
      .req_last           (req_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_order_to_index (rsp_order_to_index),
      .rsp_index_to_order (rsp_index_to_order),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_result    (rsp_last_result)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // True when the element at arrival index a sorts ahead of the one at index b.
   function automatic bit sorts_ahead(int a, int b);
      if (set_keys[a] != set_keys[b]) begin
         return cfg_descending ? (set_keys[a] > set_keys[b]) : (set_keys[a] < set_keys[b]);
      end
      return a < b;
   endfunction

   // Store one accepted value; a closing transaction ranks the set and queues its results.
   task automatic take_value(input logic signed [VALUE_WIDTH-1:0] v, input logic l);
      rank_result_type res;
      int r;
      if (set_count < MAX_ITEMS) begin
         set_keys[set_count] = v ^ SIGN_FLIP;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (l) begin
         for (int i = 0; i < set_count; i++) begin
            r = 0;
            for (int j = 0; j < set_count; j++) begin
               if (j != i && sorts_ahead(j, i)) r++;
            end
            set_rank[i] = IDX_W'(r);
            set_order[r] = IDX_W'(i);
         end
         for (int i = 0; i < set_count; i++) begin
            res.order_to_index = set_order[i];
            res.index_to_order = set_rank[i];
            res.overflow       = set_dropped;
            res.last_result    = (i == set_count - 1);
            expected_ranks.push_back(res);
         end
         set_count = 0;
         set_dropped = 1'b0;
      end
   endtask

   // Compare one accepted result with the oldest expected one.
   task automatic check_rank;
      rank_result_type exp_res;
      if (expected_ranks.size() == 0) begin
         $error("unexpected result: order_to_index %0d index_to_order %0d",
                rsp_order_to_index, rsp_index_to_order);
         errors++;
      end else begin
         exp_res = expected_ranks.pop_front();
         if (rsp_order_to_index !== exp_res.order_to_index) begin
            $error("order_to_index: expected %0d, actual %0d",
                   exp_res.order_to_index, rsp_order_to_index);
            errors++;
         end
         if (rsp_index_to_order !== exp_res.index_to_order) begin
            $error("index_to_order: expected %0d, actual %0d",
                   exp_res.index_to_order, rsp_index_to_order);
            errors++;
         end
         if (rsp_overflow !== exp_res.overflow) begin
            $error("overflow: expected %0d, actual %0d", exp_res.overflow, rsp_overflow);
            errors++;
         end
         if (rsp_last_result !== exp_res.last_result) begin
            $error("last_result: expected %0d, actual %0d",
                   exp_res.last_result, rsp_last_result);
            errors++;
         end
      end
   endtask

   // Monitor: samples every handshake at the rising edge and guards the run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         req_took = req_valid && req_ready;
         if (!reset) begin
            if (csr_valid && csr_ready) cfg_descending = csr_data;
            if (rsp_valid && rsp_ready) check_rank();
            if (req_took) take_value(req_value, req_last);
         end
      end
   end

   // Driver: offers the next pending value once the previous transaction is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_item = pending_items.pop_front();
            req_value <= next_item.value;
            req_last  <= next_item.last;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here when requested.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_cycles = HOLD_LEN;
         hold_request = 1'b0;
      end
      if (hold_cycles != 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   function automatic logic signed [VALUE_WIDTH-1:0] random_value;
      case ($urandom_range(0, 7))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2, 3: return $signed(VALUE_WIDTH'($urandom_range(0, 6))) - 3;
         default: return $signed(VALUE_WIDTH'($urandom()));
      endcase
   endfunction

   task automatic add_value(input logic signed [VALUE_WIDTH-1:0] v, input logic l);
      value_item_type it;
      it.value = v;
      it.last  = l;
      pending_items.push_back(it);
   endtask

   task automatic add_random_set(input int n);
      for (int k = 0; k < n; k++) add_value(random_value(), k == n - 1);
   endtask

   // Short random sets that add up to exactly target values.
   task automatic add_random_sets(input int target);
      int sent;
      int n;
      sent = 0;
      while (sent < target) begin
         n = $urandom_range(1, 8);
         if (n > target - sent) n = target - sent;
         add_random_set(n);
         sent += n;
      end
   endtask

   // Wait until every value is taken and every result has arrived, then let the block settle.
   task automatic wait_drained;
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_ranks.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input logic d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= d;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_mixed_set;
      add_value(5, 1'b0);
      add_value(-3, 1'b0);
      add_value(5, 1'b0);
      add_value(VALUE_MAX, 1'b0);
      add_value(VALUE_MIN, 1'b0);
      add_value(0, 1'b0);
      add_value(-1, 1'b0);
      add_value(-3, 1'b1);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      sender_idle_pct = send_pct;
      receiver_stall_pct = recv_pct;
   endtask

   // Stimulus sequence, phase by phase.
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_order(1'b0);

      // Directed: single-element sets at the extremes, then a mixed set with ties and an all-equal set in each order.
      add_value(VALUE_MAX, 1'b1);
      add_value(VALUE_MIN, 1'b1);
      add_mixed_set();
      add_value(7, 1'b0);
      add_value(7, 1'b0);
      add_value(7, 1'b0);
      add_value(7, 1'b1);
      wait_drained();
      write_order(1'b1);
      add_mixed_set();
      add_value(-7, 1'b0);
      add_value(-7, 1'b0);
      add_value(-7, 1'b1);
      wait_drained();

      // No idling, ascending.
      write_order(1'b0);
      add_random_sets(6);
      wait_drained();

      // Sender idle most of the time, descending.
      write_order(1'b1);
      set_idling(70, 0);
      add_random_sets(6);
      wait_drained();

      // Receiver stalling, ascending, with a set that fills up and closes on a dropped value.
      write_order(1'b0);
      set_idling(0, 70);
      add_random_sets(6);
      add_random_set(MAX_ITEMS + 1);
      wait_drained();

      // Both sides idling, descending.
      write_order(1'b1);
      set_idling(38, 38);
      add_random_sets(6);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering sets.
      write_order(1'b0);
      set_idling(0, 0);
      hold_request = 1'b1;
      add_random_set(3);
      add_random_set(12);
      add_random_set(3);
      wait_drained();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
